@@ hdl/lzbr_pkg.sv @@
// Shared types, constants and the long-length table of the back-reference decoder.
package lzbr_pkg;

   localparam int HISTORY_DEPTH    = 131072;
   localparam int HIST_AW          = $clog2(HISTORY_DEPTH);
   localparam int PROD_W           = HIST_AW + 1;
   localparam int BYTES_PER_RESULT = 4;
   localparam int CNT_W            = $clog2(BYTES_PER_RESULT);
   localparam int WORD_W           = 8 * BYTES_PER_RESULT;
   localparam int COUNT_W          = 3;
   localparam int LEN_W            = 9;
   localparam int OFF_W            = 17;
   localparam int RSP_DATA_W       = ((WORD_W + COUNT_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      CMD_LIT  = 2'd0,
      CMD_COPY = 2'd1,
      CMD_END  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      logic               valid;
      cmd_kind_type       kind;
      logic [7:0]         data;
      logic [LEN_W-1:0]   len;
      logic [OFF_W-1:0]   off;
   } cmd_type;

   typedef struct packed {
      logic               valid;
      logic [WORD_W-1:0]  word;
      logic [COUNT_W-1:0] count;
      logic               last;
      logic               eos;
      logic               bad;
   } emit_type;

   // Copy length of a three-byte reference, indexed by token bits 5:1.
   function automatic logic [LEN_W-1:0] long_len(input logic [4:0] idx);
      logic [LEN_W-1:0] len;
      len = LEN_W'(idx) + LEN_W'(3);
      unique case (idx)
         5'd27:   len = LEN_W'(35);
         5'd28:   len = LEN_W'(48);
         5'd29:   len = LEN_W'(72);
         5'd30:   len = LEN_W'(128);
         5'd31:   len = LEN_W'(256);
         default: len = LEN_W'(idx) + LEN_W'(3);
      endcase
      return len;
   endfunction

endpackage

@@ hdl/lz_backref_stream_decoder.sv @@
// Top level of the byte-token back-reference stream decoder.
//
// Usage: feed the compressed stream, header removed, one byte per item on
// the req_ channel. Decoded bytes leave on the rsp_ channel, up to four per
// item, earliest byte in bits 7:0, with the byte count in tdata bits 34:32.
// rsp_tlast marks the final item caused by one input byte; rsp_tuser bit 0
// flags the end token (count zero) and bit 1 a copy whose offset was zero or
// reached before the produced bytes, whose bytes then read as zeros.
// Sequencing: a literal byte and the end token are accepted, then emitted; a copy
// works byte by byte, each byte making a read and then a write of the single-port
// history window. The block is not ready while an item is being worked on.
// Results sit in one output register, so the block keeps working while a
// result waits; it pauses when a new result finds that register still full.
// Reset returns the parser to expecting a token and empties the window
// bookkeeping; history contents are not cleared and need no clearing pass.
// An end token also restarts the window so the next stream starts afresh.
module lz_backref_stream_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // in_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lzbr_pkg::RSP_DATA_W-1:0] rsp_tdata,   // out_bytes, byte_count, zero pad
   output logic                            rsp_tlast,   // last_of_run
   output logic [1:0]                      rsp_tuser    // end_of_stream, bad_offset
);
   import lzbr_pkg::*;

   cmd_type            cmd;
   emit_type           emit;
   logic               eng_idle;
   logic               accept;
   logic               slot_free;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_word_ff;
   logic [COUNT_W-1:0] rsp_cnt_ff;
   logic               rsp_last_ff;
   logic               rsp_eos_ff;
   logic               rsp_bad_ff;

   // Take a new byte only when the engine has finished the previous one.
   assign req_tready = eng_idle;
   assign accept     = req_tvalid && req_tready;
   // The output register frees up in the same cycle it is taken.
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   lzbr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .in_byte (req_tdata),
      .accept  (accept),
      .cmd     (cmd)
   );

   lzbr_copy_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .slot_free (slot_free),
      .idle      (eng_idle),
      .emit      (emit)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the payload only when the engine hands over a result.
   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_word_ff <= emit.word;
         rsp_cnt_ff  <= emit.count;
         rsp_last_ff <= emit.last;
         rsp_eos_ff  <= emit.eos;
         rsp_bad_ff  <= emit.bad;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_cnt_ff, rsp_word_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_bad_ff, rsp_eos_ff};

   // End result carries no bytes and closes the run.
   a_end_empty : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_eos_ff |-> (rsp_cnt_ff == '0) && rsp_last_ff && !rsp_bad_ff)
      else $error("end result carries bytes or lacks last");

   // Every data result carries one to four bytes.
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_eos_ff |->
         (rsp_cnt_ff != '0) && (rsp_cnt_ff <= COUNT_W'(BYTES_PER_RESULT)))
      else $error("result byte count out of range");

   // A copy with an invalid offset produces only zero bytes.
   a_bad_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> (rsp_word_ff == '0))
      else $error("bad-offset result carries nonzero data");

   // The engine never hands over a result into an occupied, stalled register.
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> slot_free)
      else $error("result produced while output register is stalled");

endmodule

@@ hdl/lzbr_parser.sv @@
// Token parser: tracks the stream phase and turns accepted bytes into commands.
module lzbr_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       in_byte,
   input  logic             accept,
   output lzbr_pkg::cmd_type cmd
);
   import lzbr_pkg::*;

   localparam logic [2:0] PH_TOKEN   = 3'd0;
   localparam logic [2:0] PH_LIT     = 3'd1;
   localparam logic [2:0] PH_BR1_LO  = 3'd2;
   localparam logic [2:0] PH_BR2_MID = 3'd3;
   localparam logic [2:0] PH_BR2_LO  = 3'd4;

   logic [2:0]       phase_ff, phase_in;
   logic [6:0]       lits_ff, lits_in;
   logic [LEN_W-1:0] plen_ff, plen_in;
   logic [OFF_W-1:0] poff_ff, poff_in;
   logic [OFF_W-1:0] poff_shift;
   logic [6:0]       lits_dec;

   assign poff_shift = {poff_ff[OFF_W-9:0], in_byte};
   assign lits_dec   = (lits_ff != 7'd0) ? lits_ff - 7'd1 : lits_ff;

   always_comb begin
      phase_in = phase_ff;
      lits_in  = lits_ff;
      plen_in  = plen_ff;
      poff_in  = poff_ff;
      cmd      = '0;
      cmd.kind = CMD_LIT;
      if (accept) begin
         unique case (phase_ff)
            PH_LIT: begin
               cmd.valid = 1'b1;
               cmd.kind  = CMD_LIT;
               cmd.data  = in_byte;
               lits_in   = lits_dec;
               phase_in  = (lits_dec == 7'd0) ? PH_TOKEN : PH_LIT;
            end
            PH_BR1_LO, PH_BR2_LO: begin
               // low offset byte completes the reference
               poff_in   = poff_shift;
               phase_in  = PH_TOKEN;
               cmd.valid = 1'b1;
               cmd.kind  = CMD_COPY;
               cmd.len   = plen_ff;
               cmd.off   = poff_shift;
            end
            PH_BR2_MID: begin
               poff_in  = poff_shift;
               phase_in = PH_BR2_LO;
            end
            default: begin
               phase_in = PH_TOKEN;
               unique case (in_byte[7:6])
                  2'b00: begin
                     lits_in  = 7'(in_byte[5:0]) + 7'd1;
                     phase_in = PH_LIT;
                  end
                  2'b01: begin
                     if (in_byte[4:0] == 5'd0) begin
                        // zero short offset: end of stream
                        cmd.valid = 1'b1;
                        cmd.kind  = CMD_END;
                        lits_in   = 7'd0;
                     end else begin
                        plen_in   = LEN_W'(3) + LEN_W'(in_byte[5]);
                        poff_in   = OFF_W'(in_byte[4:0]);
                        cmd.valid = 1'b1;
                        cmd.kind  = CMD_COPY;
                        cmd.len   = LEN_W'(3) + LEN_W'(in_byte[5]);
                        cmd.off   = OFF_W'(in_byte[4:0]);
                     end
                  end
                  2'b10: begin
                     plen_in  = LEN_W'(3) + LEN_W'(in_byte[5:3]);
                     poff_in  = OFF_W'(in_byte[2:0]);
                     phase_in = PH_BR1_LO;
                  end
                  default: begin
                     plen_in  = long_len(in_byte[5:1]);
                     poff_in  = OFF_W'(in_byte[0]);
                     phase_in = PH_BR2_MID;
                  end
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TOKEN;
         lits_ff  <= '0;
         plen_ff  <= '0;
         poff_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         lits_ff  <= lits_in;
         plen_ff  <= plen_in;
         poff_ff  <= poff_in;
      end
   end

endmodule

@@ hdl/lzbr_copy_engine.sv @@
// Byte engine: history window, shared pointer unit and result packing.
module lzbr_copy_engine (
   input  logic               clock,
   input  logic               reset,
   input  lzbr_pkg::cmd_type  cmd,
   input  logic               slot_free,
   output logic               idle,
   output lzbr_pkg::emit_type emit
);
   import lzbr_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LIT  = 3'd1;
   localparam logic [2:0] ST_END  = 3'd2;
   localparam logic [2:0] ST_RD   = 3'd3;
   localparam logic [2:0] ST_WR   = 3'd4;

   logic [7:0] hist_mem [HISTORY_DEPTH];

   logic [2:0]         st_ff, st_in;
   logic [HIST_AW-1:0] wp_ff, wp_in;
   logic [PROD_W-1:0]  bp_ff, bp_in;
   logic [HIST_AW-1:0] rp_ff, rp_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               bad_ff, bad_in;
   logic [7:0]         lit_ff, lit_in;
   logic [WORD_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [7:0]         q_ff;

   logic               push;
   logic               rd_en;
   logic [7:0]         byte_val;
   logic [WORD_W-1:0]  word_new;
   logic               last_b;
   logic               full;

   assign idle = (st_ff == ST_IDLE);

   always_comb begin
      st_in    = st_ff;
      wp_in    = wp_ff;
      bp_in    = bp_ff;
      rp_in    = rp_ff;
      len_in   = len_ff;
      bad_in   = bad_ff;
      lit_in   = lit_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      push     = 1'b0;
      rd_en    = 1'b0;
      emit     = '0;
      last_b   = (len_ff == LEN_W'(1));
      full     = (cnt_ff == CNT_W'(BYTES_PER_RESULT - 1)) || last_b;
      byte_val = bad_ff ? 8'd0 : q_ff;
      word_new = acc_ff;
      word_new[{cnt_ff, 3'b000} +: 8] = byte_val;
      unique case (st_ff)
         ST_IDLE: begin
            if (cmd.valid) begin
               unique case (cmd.kind)
                  CMD_LIT: begin
                     lit_in = cmd.data;
                     st_in  = ST_LIT;
                  end
                  CMD_END: st_in = ST_END;
                  default: begin
                     // invalid when zero or reaching before the produced bytes
                     bad_in = (cmd.off == '0) || (PROD_W'(cmd.off) > bp_ff);
                     rp_in  = wp_ff - HIST_AW'(cmd.off);
                     len_in = cmd.len;
                     acc_in = '0;
                     cnt_in = '0;
                     st_in  = ST_RD;
                  end
               endcase
            end
         end
         ST_LIT: begin
            byte_val = lit_ff;
            if (slot_free) begin
               push       = 1'b1;
               emit.valid = 1'b1;
               emit.word  = WORD_W'(lit_ff);
               emit.count = COUNT_W'(1);
               emit.last  = 1'b1;
               st_in      = ST_IDLE;
            end
         end
         ST_END: begin
            if (slot_free) begin
               emit.valid = 1'b1;
               emit.last  = 1'b1;
               emit.eos   = 1'b1;
               wp_in      = '0;
               bp_in      = '0;
               st_in      = ST_IDLE;
            end
         end
         ST_RD: begin
            rd_en = 1'b1;
            st_in = ST_WR;
         end
         ST_WR: begin
            // hold the byte while a full or final word waits for the output slot
            if (!full || slot_free) begin
               push   = 1'b1;
               rp_in  = rp_ff + HIST_AW'(1);
               len_in = len_ff - LEN_W'(1);
               if (full) begin
                  emit.valid = 1'b1;
                  emit.word  = word_new;
                  emit.count = COUNT_W'(cnt_ff) + COUNT_W'(1);
                  emit.last  = last_b;
                  emit.bad   = bad_ff;
                  acc_in     = '0;
                  cnt_in     = '0;
               end else begin
                  acc_in = word_new;
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               st_in = last_b ? ST_IDLE : ST_RD;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (push) begin
         wp_in = wp_ff + HIST_AW'(1);
         if (bp_ff != PROD_W'(HISTORY_DEPTH)) begin
            bp_in = bp_ff + PROD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         hist_mem[wp_ff] <= byte_val;
      end
      if (rd_en) begin
         q_ff <= hist_mem[rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      rp_ff  <= rp_in;
      len_ff <= len_in;
      bad_ff <= bad_in;
      lit_ff <= lit_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         wp_ff <= '0;
         bp_ff <= '0;
      end else begin
         st_ff <= st_in;
         wp_ff <= wp_in;
         bp_ff <= bp_in;
      end
   end

endmodule
